// ===== sv/double_ended_queue_assert.svh =====
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
// Package: sizes, command and fault codes, ring helpers for the deque.
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = IDX_W + 1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_QUERY      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_EMPTY = 2'd1,
    FAULT_FULL  = 2'd2
  } fault_t;

  // Write port of the slot memory.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    data_t data;
  } deq_wr_t;

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH.
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Step one slot forward around the ring.
  function automatic idx_t ring_inc(idx_t base);
    return (base == idx_t'(DEPTH - 1)) ? '0 : base + idx_t'(1);
  endfunction

  // Step one slot backward around the ring.
  function automatic idx_t ring_dec(idx_t base);
    return (base == '0) ? idx_t'(DEPTH - 1) : base - idx_t'(1);
  endfunction

endpackage

// ===== sv/deq_ram.sv =====
// Slot memory: one write port, two registered read ports (read-before-write).
module deq_ram (
  input  logic             clk,
  input  deq_pkg::deq_wr_t wr,
  input  deq_pkg::idx_t    rd_addr_a,
  input  deq_pkg::idx_t    rd_addr_b,
  output deq_pkg::data_t   rd_data_a,
  output deq_pkg::data_t   rd_data_b
);

  deq_pkg::data_t mem [deq_pkg::DEPTH];
  deq_pkg::data_t rd_a_r;
  deq_pkg::data_t rd_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/double_ended_queue.sv =====
// Top level: bounded double-ended queue kept as a ring in a slot memory.
//
//  Channel  | Ports                                  | Transfer
//  ---------+----------------------------------------+---------------------------
//  in       | start, busy, in_command, in_push_value | start && !busy at clk edge
//  out      | out_valid, out_front_value, ...        | out_valid, one cycle each
//
// One command per cycle when not busy. The accepting cycle updates head and
// count, writes a pushed value and reads the new front and back slots; the result
// appears the next cycle. A value written in that same cycle is forwarded past
// the memory's read-before-write port. busy is high until the first edge after
// reset. The receiver cannot stall; every accepted command yields one result.
`include "double_ended_queue_assert.svh"

module double_ended_queue (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_command,
  input  logic signed [deq_pkg::DATA_WIDTH-1:0] in_push_value,
  output logic                                 out_valid,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] out_front_value,
  output logic signed [deq_pkg::DATA_WIDTH-1:0] out_back_value,
  output logic [deq_pkg::CNT_W-1:0]            out_element_count,
  output logic                                 out_is_empty,
  output logic [1:0]                           out_fault
);

  logic             busy_r;
  deq_pkg::idx_t    head_r, head_nxt;
  deq_pkg::cnt_t    count_r, count_nxt;
  deq_pkg::fault_t  fault_nxt, fault_r;
  deq_pkg::deq_wr_t wr;
  deq_pkg::idx_t    back_addr;
  deq_pkg::data_t   rd_front, rd_back;
  logic             accept;
  logic             full, empty;
  logic             out_valid_r;
  logic             empty_r;
  logic             fwd_front_r, fwd_back_r;
  deq_pkg::data_t   push_val_r;

  assign accept = start && !busy_r;
  assign full   = (count_r == deq_pkg::cnt_t'(deq_pkg::DEPTH));
  assign empty  = (count_r == '0);

  // Command decode: next head, next count, fault code, slot write
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    fault_nxt = deq_pkg::FAULT_OK;
    wr.en     = 1'b0;
    wr.addr   = head_r;
    wr.data   = deq_pkg::data_t'(in_push_value);
    unique case (deq_pkg::cmd_t'(in_command))
      deq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          fault_nxt = deq_pkg::FAULT_FULL;
        end else begin
          head_nxt  = deq_pkg::ring_dec(head_r);
          count_nxt = count_r + deq_pkg::cnt_t'(1);
          wr.en     = 1'b1;
          wr.addr   = deq_pkg::ring_dec(head_r);
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          fault_nxt = deq_pkg::FAULT_FULL;
        end else begin
          count_nxt = count_r + deq_pkg::cnt_t'(1);
          wr.en     = 1'b1;
          wr.addr   = deq_pkg::ring_add(head_r, count_r);
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          fault_nxt = deq_pkg::FAULT_EMPTY;
        end else begin
          head_nxt  = deq_pkg::ring_inc(head_r);
          count_nxt = count_r - deq_pkg::cnt_t'(1);
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          fault_nxt = deq_pkg::FAULT_EMPTY;
        end else begin
          count_nxt = count_r - deq_pkg::cnt_t'(1);
        end
      end
      deq_pkg::CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        // query and unused codes leave the state alone
      end
    endcase
    if (!accept) begin
      wr.en = 1'b0;
    end
  end

  // Back slot after the step
  always_comb begin
    if (count_nxt == '0) begin
      back_addr = head_nxt;
    end else begin
      back_addr = deq_pkg::ring_add(head_nxt, count_nxt - deq_pkg::cnt_t'(1));
    end
  end

  deq_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (head_nxt),
    .rd_addr_b (back_addr),
    .rd_data_a (rd_front),
    .rd_data_b (rd_back)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Result payload and forwarding flags
  always_ff @(posedge clk) begin
    if (accept) begin
      fault_r     <= fault_nxt;
      empty_r     <= (count_nxt == '0);
      fwd_front_r <= wr.en && (wr.addr == head_nxt);
      fwd_back_r  <= wr.en && (wr.addr == back_addr);
      push_val_r  <= wr.data;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_element_count = count_r;
  assign out_is_empty      = empty_r;
  assign out_fault         = fault_r;
  assign out_front_value   = empty_r ? '0 : (fwd_front_r ? push_val_r : rd_front);
  assign out_back_value    = empty_r ? '0 : (fwd_back_r ? push_val_r : rd_back);

  // Checks
  `DEQ_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted command gave no result")
  `DEQ_ASSERT_NOW(a_fault_keeps_count, out_valid && (out_fault != deq_pkg::FAULT_OK), count_r == $past(count_r), "faulted command changed the count")
  `DEQ_ASSERT_NOW(a_count_bound, out_valid, out_element_count <= deq_pkg::cnt_t'(deq_pkg::DEPTH), "count beyond depth")
  `DEQ_ASSERT_NEXT(a_idle_holds, !accept, $stable(count_r) && $stable(head_r), "state moved without a command")

endmodule

// ===== bench/tb_double_ended_queue.sv =====
// Testbench for double_ended_queue: directed command table, then random command traffic.
`timescale 1ns / 100ps

module tb_double_ended_queue;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int BLOCK_LEN      = 40;
  localparam int MAX_GAP        = 17;
  localparam int DRAIN_CYCLES   = 8;

  // Codes outside the defined set; the block treats them as a query.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam deq_pkg::data_t VAL_MAX = {1'b0, {(deq_pkg::DATA_WIDTH-1){1'b1}}};
  localparam deq_pkg::data_t VAL_MIN = {1'b1, {(deq_pkg::DATA_WIDTH-1){1'b0}}};

  // What the block reports after one command.
  typedef struct {
    deq_pkg::data_t  front;
    deq_pkg::data_t  back;
    deq_pkg::cnt_t   count;
    logic            empty;
    deq_pkg::fault_t fault;
  } deque_view_t;

  // One row of the directed table; fixed rows carry a hand-written view.
  typedef struct {
    logic [2:0]     cmd;
    deq_pkg::data_t value;
    logic           fixed;
    deque_view_t    view;
  } table_row_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n;
  logic                                  start;
  logic                                  busy;
  logic [2:0]                            in_command;
  logic signed [deq_pkg::DATA_WIDTH-1:0] in_push_value;
  logic                                  out_valid;
  logic signed [deq_pkg::DATA_WIDTH-1:0] out_front_value;
  logic signed [deq_pkg::DATA_WIDTH-1:0] out_back_value;
  logic [deq_pkg::CNT_W-1:0]             out_element_count;
  logic                                  out_is_empty;
  logic [1:0]                            out_fault;

  // Shadow ring of the deque
  deq_pkg::data_t ring_slots [deq_pkg::DEPTH];
  int             ring_head;
  int             ring_count;

  deque_view_t pending_views [$];
  table_row_t  directed_rows [$];

  // Hand-written expectation for the command currently offered
  logic        row_fixed;
  deque_view_t row_view;

  bit failed      = 1'b0;
  int idle_cycles = 0;

  double_ended_queue u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_front_value   (out_front_value),
    .out_back_value    (out_back_value),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_fault         (out_fault)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one command to the shadow ring and return the view it leaves.
  function automatic deque_view_t deque_apply(logic [2:0] cmd, deq_pkg::data_t value);
    deque_view_t v;
    v.fault = deq_pkg::FAULT_OK;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (ring_count >= deq_pkg::DEPTH) begin
          v.fault = deq_pkg::FAULT_FULL;
        end else begin
          ring_head = (ring_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
          ring_slots[ring_head] = value;
          ring_count++;
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (ring_count >= deq_pkg::DEPTH) begin
          v.fault = deq_pkg::FAULT_FULL;
        end else begin
          ring_slots[(ring_head + ring_count) % deq_pkg::DEPTH] = value;
          ring_count++;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (ring_count == 0) begin
          v.fault = deq_pkg::FAULT_EMPTY;
        end else begin
          ring_head = (ring_head + 1) % deq_pkg::DEPTH;
          ring_count--;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (ring_count == 0) begin
          v.fault = deq_pkg::FAULT_EMPTY;
        end else begin
          ring_count--;
        end
      end
      deq_pkg::CMD_CLEAR: begin
        ring_count = 0;
        ring_head  = 0;
      end
      default: begin
      end
    endcase
    v.count = deq_pkg::cnt_t'(ring_count);
    v.empty = (ring_count == 0);
    if (v.empty) begin
      v.front = '0;
      v.back  = '0;
    end else begin
      v.front = ring_slots[ring_head];
      v.back  = ring_slots[(ring_head + ring_count - 1) % deq_pkg::DEPTH];
    end
    return v;
  endfunction

  // Idle cycles before a command: none, anywhere in 0..MAX_GAP, or mostly none.
  function automatic int draw_gap(int pace);
    case (pace)
      0:       return 0;
      1:       return $urandom_range(0, MAX_GAP);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
    endcase
  endfunction

  task automatic add_row(input logic [2:0] cmd, input deq_pkg::data_t value,
                         input logic fixed, input deq_pkg::data_t front,
                         input deq_pkg::data_t back, input deq_pkg::cnt_t count,
                         input logic empty, input deq_pkg::fault_t fault);
    table_row_t row;
    row.cmd         = cmd;
    row.value       = value;
    row.fixed       = fixed;
    row.view.front  = front;
    row.view.back   = back;
    row.view.count  = count;
    row.view.empty  = empty;
    row.view.fault  = fault;
    directed_rows   = {directed_rows, row};
  endtask

  // Offer one command; entered and left at a falling edge.
  task automatic send_command(input logic [2:0] cmd, input deq_pkg::data_t value,
                              input int gap, input logic fixed, input deque_view_t view);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         = 1'b1;
    in_command    = cmd;
    in_push_value = value;
    row_fixed     = fixed;
    row_view      = view;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Predict on each accepted command, check each result, watch for a hang.
  always @(posedge clk) begin
    deque_view_t want;
    if (rst_n) begin
      if (start && !busy) begin
        want = deque_apply(in_command, in_push_value);
        if (row_fixed) begin
          want = row_view;
        end
        pending_views = {pending_views, want};
      end
      if (out_valid) begin
        if (pending_views.size() == 0) begin
          $error("result transfer with no command pending");
          failed = 1'b1;
        end else begin
          want = pending_views[0];
          pending_views.delete(0);
          if (out_front_value !== want.front) begin
            $error("front_value: expected %0d, got %0d", $signed(want.front), out_front_value);
            failed = 1'b1;
          end
          if (out_back_value !== want.back) begin
            $error("back_value: expected %0d, got %0d", $signed(want.back), out_back_value);
            failed = 1'b1;
          end
          if (out_element_count !== want.count) begin
            $error("element_count: expected %0d, got %0d", want.count, out_element_count);
            failed = 1'b1;
          end
          if (out_is_empty !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, out_is_empty);
            failed = 1'b1;
          end
          if (out_fault !== want.fault) begin
            $error("fault: expected %0d, got %0d", want.fault, out_fault);
            failed = 1'b1;
          end
        end
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int             n;
    int             mode;
    int             pace;
    int             push_pct;
    int             pop_pct;
    int             r;
    logic [2:0]     cmd;
    deq_pkg::data_t value;
    deque_view_t    no_view;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = deq_pkg::CMD_QUERY;
    in_push_value = '0;
    row_fixed     = 1'b0;
    ring_head     = 0;
    ring_count    = 0;
    no_view       = '{front: '0, back: '0, count: '0, empty: 1'b1,
                      fault: deq_pkg::FAULT_OK};
    row_view      = no_view;

    // Empty deque: query, pops that underflow, unused codes
    add_row(deq_pkg::CMD_QUERY, '0, 1'b1, '0, '0, '0, 1'b1, deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_POP_FRONT, '0, 1'b1, '0, '0, '0, 1'b1, deq_pkg::FAULT_EMPTY);
    add_row(deq_pkg::CMD_POP_BACK, '1, 1'b1, '0, '0, '0, 1'b1, deq_pkg::FAULT_EMPTY);
    add_row(CMD_SPARE_6, VAL_MIN, 1'b1, '0, '0, '0, 1'b1, deq_pkg::FAULT_OK);
    add_row(CMD_SPARE_7, '1, 1'b1, '0, '0, '0, 1'b1, deq_pkg::FAULT_OK);
    // Extreme values at both ends; push front wraps the head below slot 0
    add_row(deq_pkg::CMD_PUSH_BACK, VAL_MAX, 1'b1, VAL_MAX, VAL_MAX, 5'd1, 1'b0,
            deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_PUSH_FRONT, VAL_MIN, 1'b1, VAL_MIN, VAL_MAX, 5'd2, 1'b0,
            deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_PUSH_FRONT, '1, 1'b1, '1, VAL_MAX, 5'd3, 1'b0,
            deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_PUSH_BACK, '0, 1'b1, '1, '0, 5'd4, 1'b0, deq_pkg::FAULT_OK);
    // Fill to full, overflow at both ends, then pop both ends and clear
    for (n = 0; n < deq_pkg::DEPTH - 4; n++) begin
      add_row((n % 2) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT,
              (n % 2) ? deq_pkg::data_t'(32'hAAAA_AAAA ^ n)
                      : deq_pkg::data_t'(32'h5555_5555 ^ n),
              1'b0, '0, '0, '0, 1'b0, deq_pkg::FAULT_OK);
    end
    add_row(deq_pkg::CMD_PUSH_BACK, deq_pkg::data_t'(32'h1234_5678), 1'b0, '0, '0, '0,
            1'b0, deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_PUSH_FRONT, deq_pkg::data_t'(32'h8765_4321), 1'b0, '0, '0, '0,
            1'b0, deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_POP_FRONT, '0, 1'b0, '0, '0, '0, 1'b0, deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_POP_BACK, '0, 1'b0, '0, '0, '0, 1'b0, deq_pkg::FAULT_OK);
    add_row(deq_pkg::CMD_CLEAR, '0, 1'b1, '0, '0, '0, 1'b1, deq_pkg::FAULT_OK);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    pace = 2;
    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].value, draw_gap(pace),
                   directed_rows[i].fixed, directed_rows[i].view);
    end

    // Random traffic in blocks that lean toward filling, draining or neither
    push_pct = 42;
    pop_pct  = 43;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        mode = $urandom_range(0, 2);
        pace = $urandom_range(0, 2);
        case (mode)
          0:       begin push_pct = 65; pop_pct = 20; end
          1:       begin push_pct = 20; pop_pct = 65; end
          default: begin push_pct = 42; pop_pct = 43; end
        endcase
      end
      // Hold off once until every result is back
      if (n == RANDOM_ITEMS / 2) begin
        start = 1'b0;
        do @(negedge clk); while (pending_views.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        cmd = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      end else if (r < push_pct + pop_pct) begin
        cmd = $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
      end else if (r < 95) begin
        cmd = deq_pkg::CMD_QUERY;
      end else if (r < 97) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
      end else begin
        cmd = deq_pkg::CMD_CLEAR;
      end
      case ($urandom_range(0, 11))
        0:       value = VAL_MAX;
        1:       value = VAL_MIN;
        2:       value = '0;
        3:       value = '1;
        default: value = $urandom();
      endcase
      send_command(cmd, value, draw_gap(pace), 1'b0, no_view);
    end
    start = 1'b0;

    // Drain: wait for the last results, then a few quiet cycles
    while (pending_views.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
